[rtl/tpa_pkg.sv]
// Package for the tile partition assigner: field widths, register indexes,
// reset values and the setup sequencer state type.
// Depends on nothing.
`timescale 1ns / 1ps

package tpa_pkg;

    localparam int COORD_BITS = 20;

    localparam int ORD_W   = 20;
    localparam int ROWS_W  = 21;
    localparam int TILE_W  = 13;
    localparam int SIZE_W  = 17;
    localparam int WORK_W  = 13;
    localparam int RANK_W  = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TILE    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SIZE    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_WORKERS = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_RANK    = CFG_IDX_W'(5);

    localparam logic [ROWS_W-1:0] RST_ROWS    = ROWS_W'(1024);
    localparam logic [ROWS_W-1:0] RST_COLS    = ROWS_W'(1024);
    localparam logic [TILE_W-1:0] RST_TILE    = TILE_W'(256);
    localparam logic [SIZE_W-1:0] RST_SIZE    = SIZE_W'(4);
    localparam logic [WORK_W-1:0] RST_WORKERS = WORK_W'(1);
    localparam logic [RANK_W-1:0] RST_RANK    = RANK_W'(0);

    // integer square root of the partition size, one digit per cycle
    localparam int SQ_W     = SIZE_W + 1;
    localparam int SQ_STEPS = (SIZE_W + 1) / 2;
    localparam int ROOT_W   = SQ_STEPS;

    // shared restoring divider of the setup sequencer
    localparam int DVD_W = 22;
    localparam int DVS_W = SIZE_W;
    localparam int CNT_W = 5;

    // per-request datapath
    localparam int G_W     = ORD_W + WORK_W;
    localparam int QB      = DVD_W;
    localparam int PA_W    = DVD_W;
    localparam int TOT_W   = 2 * DVD_W;
    localparam int PWT_W   = SIZE_W + TILE_W;
    localparam int PHT_W   = ROOT_W + TILE_W;
    localparam int LEFT_W  = QB + PWT_W;
    localparam int TOP_W   = QB + PHT_W;
    localparam int RIGHT_W = LEFT_W + 1;
    localparam int BOT_W   = TOP_W + 1;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SQRT,
        CS_PW,
        CS_TD,
        CS_TA,
        CS_PD,
        CS_PA,
        CS_MUL
    } t_cfg_state;

endpackage

[rtl/tile_partition_assigner.sv]
// Tile partition assigner: returns the pixel rectangle of the k-th partition
// dealt to this worker. Setup sequencer plus a 26-stage request pipeline.
// Depends on tpa_pkg.
`timescale 1ns / 1ps

// Usage:
//   Configuration: write registers through i_cfg_valid / o_cfg_ready with
//   i_cfg_index and i_cfg_data; o_cfg_ready is always high. Index 0 raster
//   rows, 1 raster columns, 2 tile edge, 3 tiles per partition, 4 worker
//   count, 5 worker rank. Write only while no request is in flight.
//   Each write (and reset) starts the setup sequencer, which derives the
//   partition height (square root unit), the partition width and the grid
//   sizes (shared serial divider) and the products; busy stays high until
//   the products are registered.
//   Requests: a request is taken at a clock edge with start high and busy
//   low. The result shows on o_strobe and the result ports at the end of
//   the pipeline, for one cycle only. While busy is low, a new request
//   can be taken every cycle; the 22-stage divider that splits the global
//   partition number into row and column is fully pipelined and sets most
//   of the latency. The receiver cannot stall; results are never held back.
//   Reset (synchronous, active low) loads the register reset values, clears
//   the pipeline and starts the setup sequencer.
module tile_partition_assigner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tpa_pkg::ORD_W-1:0]      i_partition_ordinal,
    output logic                           o_strobe,
    output logic                           o_valid_res,
    output logic [tpa_pkg::COORD_BITS-1:0] o_left_column,
    output logic [tpa_pkg::COORD_BITS-1:0] o_top_row,
    output logic [tpa_pkg::COORD_BITS-1:0] o_right_column,
    output logic [tpa_pkg::COORD_BITS-1:0] o_bottom_row,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [tpa_pkg::ROWS_W-1:0] r_rows;
    logic [tpa_pkg::ROWS_W-1:0] r_cols;
    logic [tpa_pkg::TILE_W-1:0] r_tile;
    logic [tpa_pkg::SIZE_W-1:0] r_size;
    logic [tpa_pkg::WORK_W-1:0] r_workers;
    logic [tpa_pkg::RANK_W-1:0] r_rank;

    logic                       cfg_we;
    logic [tpa_pkg::TILE_W-1:0] tile_e;
    logic [tpa_pkg::SIZE_W-1:0] size_e;
    logic [tpa_pkg::WORK_W-1:0] workers_e;

    // setup sequencer
    tpa_pkg::t_cfg_state       r_cfg_state;
    tpa_pkg::t_cfg_state       n_cfg_state;
    logic [tpa_pkg::CNT_W-1:0] r_cnt;
    logic [tpa_pkg::CNT_W-1:0] n_cnt;

    logic [tpa_pkg::SQ_W-1:0]  r_sq_n;
    logic [tpa_pkg::SQ_W-1:0]  r_sq_r;
    logic [tpa_pkg::SQ_W-1:0]  r_sq_bit;
    logic [tpa_pkg::SQ_W-1:0]  sq_sum;
    logic [tpa_pkg::ROOT_W-1:0] ph;

    logic [tpa_pkg::DVD_W-1:0] r_dv_q;
    logic [tpa_pkg::DVS_W-1:0] r_dv_r;
    logic [tpa_pkg::DVS_W-1:0] r_dv_d;
    logic [tpa_pkg::DVS_W:0]   dv_t;
    logic                      dv_ge;
    logic [tpa_pkg::DVD_W-1:0] dv_dividend;
    logic [tpa_pkg::DVS_W-1:0] dv_divisor;

    logic [tpa_pkg::SIZE_W-1:0] r_pw;
    logic [tpa_pkg::DVD_W-1:0]  r_td;
    logic [tpa_pkg::DVD_W-1:0]  r_ta;
    logic [tpa_pkg::DVD_W-1:0]  r_pd;
    logic [tpa_pkg::PA_W-1:0]   r_pa;
    logic [tpa_pkg::TOT_W-1:0]  r_total;
    logic [tpa_pkg::PWT_W-1:0]  r_pwt;
    logic [tpa_pkg::PHT_W-1:0]  r_pht;
    logic                       r_rank_ok;

    // request pipeline
    logic                      in_take;
    logic                      r_a_vld;
    logic [tpa_pkg::G_W-1:0]   r_a_g;

    logic                      r_dq_vld [0:tpa_pkg::QB];
    logic                      r_dq_ok  [0:tpa_pkg::QB];
    logic [tpa_pkg::PA_W-1:0]  r_dq_rem [0:tpa_pkg::QB];
    logic [tpa_pkg::QB-1:0]    r_dq_q   [0:tpa_pkg::QB];

    logic                       r_m_vld;
    logic                       r_m_ok;
    logic [tpa_pkg::LEFT_W-1:0] r_m_left;
    logic [tpa_pkg::TOP_W-1:0]  r_m_top;

    logic [tpa_pkg::RIGHT_W-1:0] n_right;
    logic [tpa_pkg::BOT_W-1:0]   n_bottom;

    logic                           r_strobe;
    logic                           r_out_valid;
    logic [tpa_pkg::COORD_BITS-1:0] r_out_left;
    logic [tpa_pkg::COORD_BITS-1:0] r_out_top;
    logic [tpa_pkg::COORD_BITS-1:0] r_out_right;
    logic [tpa_pkg::COORD_BITS-1:0] r_out_bottom;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= tpa_pkg::RST_ROWS;
            r_cols    <= tpa_pkg::RST_COLS;
            r_tile    <= tpa_pkg::RST_TILE;
            r_size    <= tpa_pkg::RST_SIZE;
            r_workers <= tpa_pkg::RST_WORKERS;
            r_rank    <= tpa_pkg::RST_RANK;
        end else if (cfg_we) begin
            case (i_cfg_index)
                tpa_pkg::REG_ROWS:    r_rows    <= i_cfg_data[tpa_pkg::ROWS_W-1:0];
                tpa_pkg::REG_COLS:    r_cols    <= i_cfg_data[tpa_pkg::ROWS_W-1:0];
                tpa_pkg::REG_TILE:    r_tile    <= i_cfg_data[tpa_pkg::TILE_W-1:0];
                tpa_pkg::REG_SIZE:    r_size    <= i_cfg_data[tpa_pkg::SIZE_W-1:0];
                tpa_pkg::REG_WORKERS: r_workers <= i_cfg_data[tpa_pkg::WORK_W-1:0];
                tpa_pkg::REG_RANK:    r_rank    <= i_cfg_data[tpa_pkg::RANK_W-1:0];
                default: ;
            endcase
        end
    end

    // zero divisors count as one
    always_comb begin
        tile_e    = (r_tile == '0)    ? tpa_pkg::TILE_W'(1) : r_tile;
        size_e    = (r_size == '0)    ? tpa_pkg::SIZE_W'(1) : r_size;
        workers_e = (r_workers == '0) ? tpa_pkg::WORK_W'(1) : r_workers;
    end

    // ---------------- setup sequencer ----------------

    always_comb begin
        n_cfg_state = r_cfg_state;
        n_cnt       = r_cnt + tpa_pkg::CNT_W'(1);
        case (r_cfg_state)
            tpa_pkg::CS_IDLE: begin
                n_cnt = '0;
            end
            tpa_pkg::CS_SQRT: begin
                if (r_cnt == tpa_pkg::CNT_W'(tpa_pkg::SQ_STEPS)) begin
                    n_cfg_state = tpa_pkg::CS_PW;
                    n_cnt       = '0;
                end
            end
            tpa_pkg::CS_PW, tpa_pkg::CS_TD, tpa_pkg::CS_TA, tpa_pkg::CS_PD,
            tpa_pkg::CS_PA: begin
                if (r_cnt == tpa_pkg::CNT_W'(tpa_pkg::DVD_W)) begin
                    n_cnt = '0;
                    case (r_cfg_state)
                        tpa_pkg::CS_PW: n_cfg_state = tpa_pkg::CS_TD;
                        tpa_pkg::CS_TD: n_cfg_state = tpa_pkg::CS_TA;
                        tpa_pkg::CS_TA: n_cfg_state = tpa_pkg::CS_PD;
                        tpa_pkg::CS_PD: n_cfg_state = tpa_pkg::CS_PA;
                        default:        n_cfg_state = tpa_pkg::CS_MUL;
                    endcase
                end
            end
            tpa_pkg::CS_MUL: begin
                if (r_cnt == tpa_pkg::CNT_W'(1)) begin
                    n_cfg_state = tpa_pkg::CS_IDLE;
                    n_cnt       = '0;
                end
            end
            default: begin
                n_cfg_state = tpa_pkg::CS_IDLE;
                n_cnt       = '0;
            end
        endcase
        if (cfg_we) begin
            n_cfg_state = tpa_pkg::CS_SQRT;
            n_cnt       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_state <= tpa_pkg::CS_SQRT;
            r_cnt       <= '0;
        end else begin
            r_cfg_state <= n_cfg_state;
            r_cnt       <= n_cnt;
        end
    end

    always_comb begin
        busy = (r_cfg_state != tpa_pkg::CS_IDLE);
    end

    assign ph     = r_sq_r[tpa_pkg::ROOT_W-1:0];
    assign sq_sum = r_sq_r + r_sq_bit;
    assign dv_t   = {r_dv_r, r_dv_q[tpa_pkg::DVD_W-1]};
    assign dv_ge  = (dv_t >= {1'b0, r_dv_d});

    always_comb begin
        dv_dividend = tpa_pkg::DVD_W'(size_e);
        dv_divisor  = tpa_pkg::DVS_W'(ph);
        case (r_cfg_state)
            tpa_pkg::CS_TD: begin
                dv_dividend = tpa_pkg::DVD_W'(r_rows) + tpa_pkg::DVD_W'(tile_e)
                              - tpa_pkg::DVD_W'(1);
                dv_divisor  = tpa_pkg::DVS_W'(tile_e);
            end
            tpa_pkg::CS_TA: begin
                dv_dividend = tpa_pkg::DVD_W'(r_cols) + tpa_pkg::DVD_W'(tile_e)
                              - tpa_pkg::DVD_W'(1);
                dv_divisor  = tpa_pkg::DVS_W'(tile_e);
            end
            tpa_pkg::CS_PD: begin
                dv_dividend = r_td + tpa_pkg::DVD_W'(ph) - tpa_pkg::DVD_W'(1);
                dv_divisor  = tpa_pkg::DVS_W'(ph);
            end
            tpa_pkg::CS_PA: begin
                dv_dividend = r_ta + tpa_pkg::DVD_W'(r_pw) - tpa_pkg::DVD_W'(1);
                dv_divisor  = r_pw;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_cfg_state)
            tpa_pkg::CS_SQRT: begin
                if (r_cnt == '0) begin
                    r_sq_n   <= tpa_pkg::SQ_W'(size_e);
                    r_sq_r   <= '0;
                    r_sq_bit <= tpa_pkg::SQ_W'(1) << (2 * (tpa_pkg::SQ_STEPS - 1));
                end else begin
                    if (r_sq_n >= sq_sum) begin
                        r_sq_n <= r_sq_n - sq_sum;
                        r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                end
            end
            tpa_pkg::CS_PW, tpa_pkg::CS_TD, tpa_pkg::CS_TA, tpa_pkg::CS_PD,
            tpa_pkg::CS_PA: begin
                if (r_cnt == '0) begin
                    case (r_cfg_state)
                        tpa_pkg::CS_TD: r_pw <= r_dv_q[tpa_pkg::SIZE_W-1:0];
                        tpa_pkg::CS_TA: r_td <= r_dv_q;
                        tpa_pkg::CS_PD: r_ta <= r_dv_q;
                        tpa_pkg::CS_PA: r_pd <= r_dv_q;
                        default: ;
                    endcase
                    r_dv_q <= dv_dividend;
                    r_dv_r <= '0;
                    r_dv_d <= dv_divisor;
                end else begin
                    r_dv_r <= dv_ge ? tpa_pkg::DVS_W'(dv_t - {1'b0, r_dv_d})
                                    : dv_t[tpa_pkg::DVS_W-1:0];
                    r_dv_q <= {r_dv_q[tpa_pkg::DVD_W-2:0], dv_ge};
                end
            end
            tpa_pkg::CS_MUL: begin
                if (r_cnt == '0) begin
                    r_pa <= r_dv_q;
                end else begin
                    r_total   <= tpa_pkg::TOT_W'(r_pd) * tpa_pkg::TOT_W'(r_pa);
                    r_pwt     <= tpa_pkg::PWT_W'(r_pw) * tpa_pkg::PWT_W'(tile_e);
                    r_pht     <= tpa_pkg::PHT_W'(ph) * tpa_pkg::PHT_W'(tile_e);
                    r_rank_ok <= (tpa_pkg::WORK_W'(r_rank) < workers_e);
                end
            end
            default: ;
        endcase
    end

    // ---------------- request pipeline ----------------

    assign in_take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_g <= tpa_pkg::G_W'(r_rank)
                 + tpa_pkg::G_W'(i_partition_ordinal) * tpa_pkg::G_W'(workers_e);
    end

    // load the divider: high part of the global number is the first remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dq_vld[0] <= 1'b0;
        end else begin
            r_dq_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq_ok[0]  <= r_rank_ok && (tpa_pkg::TOT_W'(r_a_g) < r_total);
        r_dq_rem[0] <= tpa_pkg::PA_W'(r_a_g[tpa_pkg::G_W-1:tpa_pkg::QB]);
        r_dq_q[0]   <= r_a_g[tpa_pkg::QB-1:0];
    end

    for (genvar j = 0; j < tpa_pkg::QB; j++) begin : g_div
        logic [tpa_pkg::PA_W:0] t;
        logic                   ge;

        assign t  = {r_dq_rem[j], r_dq_q[j][tpa_pkg::QB-1]};
        assign ge = (t >= {1'b0, r_pa});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dq_vld[j+1] <= 1'b0;
            end else begin
                r_dq_vld[j+1] <= r_dq_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dq_ok[j+1]  <= r_dq_ok[j];
            r_dq_rem[j+1] <= ge ? tpa_pkg::PA_W'(t - {1'b0, r_pa})
                                : t[tpa_pkg::PA_W-1:0];
            r_dq_q[j+1]   <= {r_dq_q[j][tpa_pkg::QB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_dq_vld[tpa_pkg::QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_ok   <= r_dq_ok[tpa_pkg::QB];
        r_m_left <= tpa_pkg::LEFT_W'(r_dq_rem[tpa_pkg::QB]) * tpa_pkg::LEFT_W'(r_pwt);
        r_m_top  <= tpa_pkg::TOP_W'(r_dq_q[tpa_pkg::QB]) * tpa_pkg::TOP_W'(r_pht);
    end

    // clamp the far edges to the raster
    always_comb begin
        n_right  = tpa_pkg::RIGHT_W'(r_m_left) + tpa_pkg::RIGHT_W'(r_pwt)
                   - tpa_pkg::RIGHT_W'(1);
        n_bottom = tpa_pkg::BOT_W'(r_m_top) + tpa_pkg::BOT_W'(r_pht)
                   - tpa_pkg::BOT_W'(1);
        if (n_right >= tpa_pkg::RIGHT_W'(r_cols)) begin
            n_right = tpa_pkg::RIGHT_W'(r_cols) - tpa_pkg::RIGHT_W'(1);
        end
        if (n_bottom >= tpa_pkg::BOT_W'(r_rows)) begin
            n_bottom = tpa_pkg::BOT_W'(r_rows) - tpa_pkg::BOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_valid  <= r_m_ok;
        r_out_left   <= r_m_ok ? r_m_left[tpa_pkg::COORD_BITS-1:0] : '0;
        r_out_top    <= r_m_ok ? r_m_top[tpa_pkg::COORD_BITS-1:0]  : '0;
        r_out_right  <= r_m_ok ? n_right[tpa_pkg::COORD_BITS-1:0]  : '0;
        r_out_bottom <= r_m_ok ? n_bottom[tpa_pkg::COORD_BITS-1:0] : '0;
    end

    assign o_strobe       = r_strobe;
    assign o_valid_res    = r_out_valid;
    assign o_left_column  = r_out_left;
    assign o_top_row      = r_out_top;
    assign o_right_column = r_out_right;
    assign o_bottom_row   = r_out_bottom;

`ifndef SYNTH
    a_cfg_restarts_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> busy)
        else $error("setup sequencer did not restart after a register write");

    a_root_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |->
            ((r_sq_r * r_sq_r) <= tpa_pkg::SQ_W'(size_e))
            && (((r_sq_r + tpa_pkg::SQ_W'(1)) * (r_sq_r + tpa_pkg::SQ_W'(1)))
                > tpa_pkg::SQ_W'(size_e)))
        else $error("partition height is not the integer square root");

    a_width_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |->
            ((tpa_pkg::SQ_W'(r_pw) * r_sq_r) <= tpa_pkg::SQ_W'(size_e))
            && ((tpa_pkg::SQ_W'(size_e) - tpa_pkg::SQ_W'(r_pw) * r_sq_r) < r_sq_r))
        else $error("partition width is not size divided by height");

    a_past_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |->
            (o_left_column == '0) && (o_top_row == '0)
            && (o_right_column == '0) && (o_bottom_row == '0))
        else $error("result past the end carries nonzero coordinates");
`endif

endmodule
